// ===== rtl/esas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esas_pkg
// Shared widths, constants, register indexes and controller/datapath types
// for the adaptive-alpha encoder speed smoother.
// ----------------------------------------------------------------------------
package esas_pkg;

  // fixed-point format of speeds and accelerations
  localparam int FRAC_BITS  = 16;
  localparam int UP_SHIFT   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DOWN_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // field widths
  localparam int COUNT_W = 32;
  localparam int US_W    = 20;
  localparam int DPC_W   = 16;
  localparam int ALPHA_W = 17;
  localparam int AFS_W   = 20;
  localparam int SPEED_W = 48;
  localparam int MAG_W   = SPEED_W - 1;

  // internal widths
  localparam int NUM_W   = 48 + UP_SHIFT;        // count * degrees, rescaled
  localparam int N_W     = NUM_W + US_W;         // numerator times 1e6
  localparam int ACC_W   = N_W + 1;              // signed accumulator
  localparam int QUO_W   = 48;                   // time-division quotient
  localparam int DHI_W   = N_W - QUO_W;          // numerator bits above quotient
  localparam int FS_W    = AFS_W + FRAC_BITS;    // full-scale acceleration
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divider sequencing
  localparam int TIME_STEPS = QUO_W / 2;         // two quotient bits a cycle
  localparam int FRAC_STEPS = 16;                // one quotient bit a cycle
  localparam int CNT_W      = $clog2(TIME_STEPS + 1);

  // constants
  localparam int                 US_PER_S = 1000000;
  localparam logic [MAG_W-1:0]   MAG_CAP  = '1;
  localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_DPC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AFS  = 3'd3;

  localparam logic [DPC_W-1:0]   DPC_RESET  = 16'd8426;
  localparam logic [ALPHA_W-1:0] BASE_RESET = 17'd3277;
  localparam logic [ALPHA_W-1:0] MAX_RESET  = 17'd32768;
  localparam logic [AFS_W-1:0]   AFS_RESET  = 20'd10000;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_MAG_DPC = 3'd0,
    MUL_NUM_LO  = 3'd1,
    MUL_NUM_HI  = 3'd2,
    MUL_ALPHA   = 3'd3,
    MUL_RAW_LO  = 3'd4,
    MUL_RAW_HI  = 3'd5,
    MUL_PREV_LO = 3'd6,
    MUL_PREV_HI = 3'd7
  } mul_sel_e;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD  = 3'd0,
    ACC_LOAD  = 3'd1,
    ACC_ADD0  = 3'd2,
    ACC_ADD24 = 3'd3,
    ACC_ADD32 = 3'd4
  } acc_op_e;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     num_prod;
    logic     num_diff;
    logic     div_time;
    logic     div_frac;
    logic     raw_load;
    logic     amag_load;
    logic     scale_one;
    logic     scale_load;
    logic     alpha_load;
    logic     result_load;
  } esas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic amag_ge_fs;
    logic out_free;
  } esas_status_t;

endpackage
`default_nettype wire

// ===== rtl/esas_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esas_ctrl
// Sequencer: walks one request through the multiply, divide and smoothing
// steps by issuing datapath commands.
// ----------------------------------------------------------------------------
module esas_ctrl
  import esas_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire esas_status_t status_i,
  output esas_cmd_t         cmd_o
);

  typedef enum logic [21:0] {
    ST_IDLE   = 22'h000001,
    ST_MAG    = 22'h000002,
    ST_NUM    = 22'h000004,
    ST_NLO    = 22'h000008,
    ST_NHI    = 22'h000010,
    ST_NACC   = 22'h000020,
    ST_DINIT  = 22'h000040,
    ST_DIV    = 22'h000080,
    ST_RAW    = 22'h000100,
    ST_DIFF   = 22'h000200,
    ST_SCMP   = 22'h000400,
    ST_SDIV   = 22'h000800,
    ST_SEND   = 22'h001000,
    ST_ALPHA0 = 22'h002000,
    ST_ALPHA1 = 22'h004000,
    ST_SM0    = 22'h008000,
    ST_SM1    = 22'h010000,
    ST_SM2    = 22'h020000,
    ST_SM3    = 22'h040000,
    ST_SM4    = 22'h080000,
    ST_OUT    = 22'h100000,
    ST_SPARE  = 22'h200000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    pass_d        = pass_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_MAG_DPC;
    cmd_o.acc_op  = ACC_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd_o.mul_sel = MUL_MAG_DPC;
        state_d       = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num_prod = 1'b1;
        pass_d         = 1'b0;
        state_d        = ST_NLO;
      end
      ST_NLO: begin
        cmd_o.mul_sel = MUL_NUM_LO;
        state_d       = ST_NHI;
      end
      ST_NHI: begin
        cmd_o.mul_sel = MUL_NUM_HI;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_NACC;
      end
      ST_NACC: begin
        cmd_o.acc_op = ACC_ADD32;
        state_d      = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_time = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_RAW;
        end
      end
      ST_RAW: begin
        // first pass yields the speed, second the acceleration
        if (!pass_q) begin
          cmd_o.raw_load = 1'b1;
          state_d        = ST_DIFF;
        end else begin
          cmd_o.amag_load = 1'b1;
          state_d         = ST_SCMP;
        end
      end
      ST_DIFF: begin
        cmd_o.num_diff = 1'b1;
        pass_d         = 1'b1;
        state_d        = ST_NLO;
      end
      ST_SCMP: begin
        if (status_i.amag_ge_fs) begin
          cmd_o.scale_one = 1'b1;
          state_d         = ST_ALPHA0;
        end else begin
          cmd_o.div_frac = 1'b1;
          state_d        = ST_SDIV;
        end
      end
      ST_SDIV: begin
        if (status_i.div_last) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd_o.scale_load = 1'b1;
        state_d          = ST_ALPHA0;
      end
      ST_ALPHA0: begin
        cmd_o.mul_sel = MUL_ALPHA;
        state_d       = ST_ALPHA1;
      end
      ST_ALPHA1: begin
        cmd_o.alpha_load = 1'b1;
        state_d          = ST_SM0;
      end
      ST_SM0: begin
        cmd_o.mul_sel = MUL_RAW_LO;
        state_d       = ST_SM1;
      end
      ST_SM1: begin
        cmd_o.mul_sel = MUL_RAW_HI;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_SM2;
      end
      ST_SM2: begin
        cmd_o.mul_sel = MUL_PREV_LO;
        cmd_o.acc_op  = ACC_ADD24;
        state_d       = ST_SM3;
      end
      ST_SM3: begin
        cmd_o.mul_sel = MUL_PREV_HI;
        cmd_o.acc_op  = ACC_ADD0;
        state_d       = ST_SM4;
      end
      ST_SM4: begin
        cmd_o.acc_op = ACC_ADD24;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/esas_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esas_div
// Serial restoring divider. Time mode divides the scaled numerator by the
// elapsed time, two quotient bits a cycle, and flags a quotient past 48 bits.
// Fraction mode forms the 16-bit acceleration scale, one bit a cycle.
// ----------------------------------------------------------------------------
module esas_div
  import esas_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_time_i,
  input  wire logic             start_frac_i,
  input  wire logic [DHI_W-1:0] dvd_hi_i,
  input  wire logic [QUO_W-1:0] dvd_lo_i,
  input  wire logic [US_W-1:0]  us_i,
  input  wire logic [FS_W-1:0]  fs_i,
  input  wire logic [FS_W-1:0]  frac_rem_i,
  output logic [QUO_W-1:0]      quo_o,
  output logic                  cap_o,
  output logic                  last_o
);

  logic [FS_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             frac_q, frac_d;
  logic             cap_q, cap_d;

  // time-mode steps on the narrow remainder
  logic [US_W:0]   t1, t2;
  logic [US_W-1:0] r1, r2;
  logic            q1, q2;
  // fraction-mode step on the wide remainder
  logic [FS_W:0]   tf;
  logic [FS_W-1:0] rf;
  logic            qf;
  logic            cap_init;

  assign t1 = {rem_q[US_W-1:0], dvd_q[QUO_W-1]};
  assign q1 = (t1 >= {1'b0, us_i});
  assign r1 = q1 ? US_W'(t1 - {1'b0, us_i}) : t1[US_W-1:0];
  assign t2 = {r1, dvd_q[QUO_W-2]};
  assign q2 = (t2 >= {1'b0, us_i});
  assign r2 = q2 ? US_W'(t2 - {1'b0, us_i}) : t2[US_W-1:0];

  assign tf = {rem_q, 1'b0};
  assign qf = (tf >= {1'b0, fs_i});
  assign rf = qf ? FS_W'(tf - {1'b0, fs_i}) : tf[FS_W-1:0];

  // quotient at or past 2^48 when the top part already reaches the divisor
  assign cap_init = (dvd_hi_i >= DHI_W'(us_i));

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    frac_d = frac_q;
    cap_d  = cap_q;
    if (start_time_i) begin
      rem_d  = cap_init ? '0 : FS_W'(dvd_hi_i[US_W-1:0]);
      dvd_d  = dvd_lo_i;
      quo_d  = '0;
      cnt_d  = CNT_W'(TIME_STEPS);
      frac_d = 1'b0;
      cap_d  = cap_init;
    end else if (start_frac_i) begin
      rem_d  = frac_rem_i;
      quo_d  = '0;
      cnt_d  = CNT_W'(FRAC_STEPS);
      frac_d = 1'b1;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (frac_q) begin
        rem_d = rf;
        quo_d = {quo_q[QUO_W-2:0], qf};
      end else begin
        rem_d = FS_W'(r2);
        dvd_d = {dvd_q[QUO_W-3:0], 2'b00};
        quo_d = {quo_q[QUO_W-3:0], q1, q2};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      frac_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      frac_q <= frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    cap_q <= cap_d;
  end

  assign quo_o  = quo_q;
  assign cap_o  = cap_q;
  assign last_o = (cnt_q == CNT_W'(1));

endmodule
`default_nettype wire

// ===== rtl/esas_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esas_dp
// Datapath: configuration registers, filter state, a shared 33x21 signed
// multiplier with accumulator, the serial divider and the output register.
// ----------------------------------------------------------------------------
module esas_dp
  import esas_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [COUNT_W-1:0]    pulse_count_i,
  input  wire logic [US_W-1:0]       elapsed_us_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [SPEED_W-1:0]         filtered_speed_o,
  input  wire esas_cmd_t             cmd_i,
  output esas_status_t               status_o
);

  // configuration
  logic [DPC_W-1:0]   dpc_q;
  logic [ALPHA_W-1:0] base_q, max_q;
  logic [AFS_W-1:0]   afs_q;

  // filter state
  logic [COUNT_W-1:0]        prev_count_q;
  logic signed [SPEED_W-1:0] prev_raw_q, prev_smooth_q;

  // per-request registers
  logic [US_W-1:0]           us_q;
  logic                      neg_q;
  logic [COUNT_W-1:0]        mag_q;
  logic [NUM_W-1:0]          num_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SPEED_W-1:0] raw_q;
  logic [MAG_W-1:0]          amag_q;
  logic [ALPHA_W-1:0]        scale_q, alpha_q;
  logic [SPEED_W-1:0]        out_q;
  logic                      out_valid_q;

  // combinational
  logic [COUNT_W-1:0]        delta;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [ACC_W-1:0]   prod_ext;
  logic [QUO_W-1:0]          quo;
  logic                      div_cap;
  logic                      div_last;
  logic [MAG_W-1:0]          mag_sat;
  logic [SPEED_W-1:0]        mag_ext, raw_new;
  logic [SPEED_W:0]          diff, adiff;
  logic [FS_W-1:0]           fs;
  logic [ALPHA_W-1:0]        base_c, top_c, one_minus_alpha;
  logic signed [17:0]        top_minus_base;
  logic signed [23:0]        raw_hi, prev_hi;
  logic signed [PROD_W-1:0]  ap_bias, ap_shift;
  logic [18:0]               alpha_sum;
  logic signed [ACC_W-1:0]   sm_bias, sm_shift;
  logic [NUM_W-1:0]          num_scaled;

  // clamp alpha registers to one
  assign base_c = (base_q > ONE_Q16) ? ONE_Q16 : base_q;
  assign top_c  = (max_q > ONE_Q16) ? ONE_Q16 : max_q;
  assign top_minus_base  = $signed({1'b0, top_c}) - $signed({1'b0, base_c});
  assign one_minus_alpha = ONE_Q16 - alpha_q;

  assign raw_hi  = raw_q[SPEED_W-1:24];
  assign prev_hi = prev_smooth_q[SPEED_W-1:24];

  assign delta = pulse_count_i - prev_count_q;
  assign fs    = {afs_q, {FRAC_BITS{1'b0}}};

  // select multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_MAG_DPC: begin
        mul_a = {1'b0, mag_q};
        mul_b = MUL_B_W'(dpc_q);
      end
      MUL_NUM_LO: begin
        mul_a = {1'b0, num_q[31:0]};
        mul_b = MUL_B_W'(US_PER_S);
      end
      MUL_NUM_HI: begin
        mul_a = MUL_A_W'(num_q[NUM_W-1:32]);
        mul_b = MUL_B_W'(US_PER_S);
      end
      MUL_ALPHA: begin
        mul_a = MUL_A_W'(top_minus_base);
        mul_b = MUL_B_W'(scale_q);
      end
      MUL_RAW_LO: begin
        mul_a = MUL_A_W'(raw_q[23:0]);
        mul_b = MUL_B_W'(alpha_q);
      end
      MUL_RAW_HI: begin
        mul_a = MUL_A_W'(raw_hi);
        mul_b = MUL_B_W'(alpha_q);
      end
      MUL_PREV_LO: begin
        mul_a = MUL_A_W'(prev_smooth_q[23:0]);
        mul_b = MUL_B_W'(one_minus_alpha);
      end
      MUL_PREV_HI: begin
        mul_a = MUL_A_W'(prev_hi);
        mul_b = MUL_B_W'(one_minus_alpha);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_q);

  // accumulate partial products
  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_HOLD:  acc_d = acc_q;
      ACC_LOAD:  acc_d = prod_ext;
      ACC_ADD0:  acc_d = acc_q + prod_ext;
      ACC_ADD24: acc_d = acc_q + (prod_ext <<< 24);
      ACC_ADD32: acc_d = acc_q + (prod_ext <<< 32);
      default:   acc_d = acc_q;
    endcase
  end

  // rescale count times degrees into the speed format
  assign num_scaled = (NUM_W'(prod_q[SPEED_W-1:0]) << UP_SHIFT) >> DOWN_SHIFT;

  esas_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_time_i (cmd_i.div_time),
    .start_frac_i (cmd_i.div_frac),
    .dvd_hi_i     (acc_q[N_W-1:QUO_W]),
    .dvd_lo_i     (acc_q[QUO_W-1:0]),
    .us_i         (us_q),
    .fs_i         (fs),
    .frac_rem_i   (amag_q[FS_W-1:0]),
    .quo_o        (quo),
    .cap_o        (div_cap),
    .last_o       (div_last)
  );

  // saturate the time quotient and apply the sign
  assign mag_sat = (div_cap || quo[QUO_W-1]) ? MAG_CAP : quo[MAG_W-1:0];
  assign mag_ext = {1'b0, mag_sat};
  assign raw_new = neg_q ? (SPEED_W'(0) - mag_ext) : mag_ext;

  // speed change magnitude
  assign diff  = {raw_q[SPEED_W-1], raw_q} - {prev_raw_q[SPEED_W-1], prev_raw_q};
  assign adiff = diff[SPEED_W] ? ((SPEED_W + 1)'(0) - diff) : diff;

  // alpha = base + (top - base) * s / 1.0, truncated toward zero
  assign ap_bias   = prod_q + (prod_q[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign ap_shift  = ap_bias >>> 16;
  assign alpha_sum = {2'b00, base_c} + ap_shift[18:0];

  // smoothed = sum / 1.0, truncated toward zero
  assign sm_bias  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
  assign sm_shift = sm_bias >>> 16;

  // configuration writes and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q         <= DPC_RESET;
      base_q        <= BASE_RESET;
      max_q         <= MAX_RESET;
      afs_q         <= AFS_RESET;
      prev_count_q  <= '0;
      prev_raw_q    <= '0;
      prev_smooth_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DPC:  dpc_q  <= cfg_wdata_i[DPC_W-1:0];
          CFG_BASE: base_q <= cfg_wdata_i[ALPHA_W-1:0];
          CFG_MAX:  max_q  <= cfg_wdata_i[ALPHA_W-1:0];
          CFG_AFS:  afs_q  <= cfg_wdata_i[AFS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load_in) begin
        prev_count_q <= pulse_count_i;
      end
      if (cmd_i.result_load) begin
        prev_raw_q    <= raw_q;
        prev_smooth_q <= sm_shift[SPEED_W-1:0];
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-request payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.load_in) begin
      us_q  <= (elapsed_us_i == '0) ? US_W'(1) : elapsed_us_i;
      neg_q <= delta[COUNT_W-1];
      mag_q <= delta[COUNT_W-1] ? (COUNT_W'(0) - delta) : delta;
    end
    if (cmd_i.num_prod) begin
      num_q <= num_scaled;
    end else if (cmd_i.num_diff) begin
      num_q <= NUM_W'(adiff[SPEED_W-1:0]);
    end
    if (cmd_i.raw_load) begin
      raw_q <= raw_new;
    end
    if (cmd_i.amag_load) begin
      amag_q <= mag_sat;
    end
    if (cmd_i.scale_one) begin
      scale_q <= ONE_Q16;
    end else if (cmd_i.scale_load) begin
      scale_q <= {1'b0, quo[15:0]};
    end
    if (cmd_i.alpha_load) begin
      alpha_q <= alpha_sum[ALPHA_W-1:0];
    end
    if (cmd_i.result_load) begin
      out_q <= sm_shift[SPEED_W-1:0];
    end
  end

  assign status_o.div_last   = div_last;
  assign status_o.amag_ge_fs = (amag_q >= MAG_W'(fs));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign filtered_speed_o = out_q;

endmodule
`default_nettype wire

// ===== rtl/encoder_speed_adaptive_smoother_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_adaptive_smoother_core
// Adaptive-alpha moving average of encoder shaft speed.
// ----------------------------------------------------------------------------
// Flow: a request is taken only when the sequencer is idle, so each request runs
//   through the two time divisions and the scale division of the serial divider
//   before the next is accepted; the scale division is skipped when the
//   acceleration reaches full scale. A finished result waits in the output register,
//   and the sequencer holds until that register is free.
// Reset: clears the filter state and loads the default configuration.
// ----------------------------------------------------------------------------
module encoder_speed_adaptive_smoother_core
  import esas_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COUNT_W-1:0]    pulse_count_i,
  input  wire logic [US_W-1:0]       elapsed_us_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [SPEED_W-1:0]         filtered_speed_o
);

  esas_cmd_t    cmd;
  esas_status_t status;

  // sequence each request
  esas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  esas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pulse_count_i    (pulse_count_i),
    .elapsed_us_i     (elapsed_us_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .filtered_speed_o (filtered_speed_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule
`default_nettype wire

// ===== tb/sv/encoder_speed_adaptive_smoother_core_tb.sv =====
// ----------------------------------------------------------------------------
// encoder_speed_adaptive_smoother_core_tb
// Self-checking bench for the adaptive-alpha encoder speed smoother. Pulse
// count samples go in over a valid/ready request channel. The bench keeps a
// bit-exact copy of the filter and its registers and compares every returned
// speed against it. It covers corner samples and register settings first,
// then long stretches of shaft motion with noise under random stalls.
// ----------------------------------------------------------------------------
module encoder_speed_adaptive_smoother_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esas_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 100;
  localparam longint      UNITY       = 65536;
  localparam logic [63:0] SPEED_CAP   = 64'(MAG_CAP);
  localparam logic [63:0] USEC_PER_S  = 64'(US_PER_S);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [COUNT_W-1:0]    pulse_count;
  logic [US_W-1:0]       elapsed_us;
  logic                  out_valid;
  logic                  out_ready;
  logic [SPEED_W-1:0]    filtered_speed;

  // shadow registers and filter state
  logic [DPC_W-1:0]   sh_dpc  = DPC_RESET;
  logic [ALPHA_W-1:0] sh_base = BASE_RESET;
  logic [ALPHA_W-1:0] sh_max  = MAX_RESET;
  logic [AFS_W-1:0]   sh_afs  = AFS_RESET;
  logic [COUNT_W-1:0] last_count  = '0;
  longint             last_raw    = 0;
  longint             last_smooth = 0;

  logic [SPEED_W-1:0] pending_speed_q[$];
  logic               idle_on = 1'b1;
  logic [COUNT_W-1:0] shaft_count = '0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;

  encoder_speed_adaptive_smoother_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .pulse_count_i    (pulse_count),
    .elapsed_us_i     (elapsed_us),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .filtered_speed_o (filtered_speed)
  );

  always #2 clk = ~clk;

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // a * 1e6 / d, truncated, held at the speed cap
  function automatic logic [63:0] per_second(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] v;
    q = a / d;
    r = a % d;
    if (q > SPEED_CAP / USEC_PER_S) return SPEED_CAP;
    v = q * USEC_PER_S + (r * USEC_PER_S) / d;
    return (v > SPEED_CAP) ? SPEED_CAP : v;
  endfunction

  // advance the shadow filter by one sample and return its smoothed speed
  task automatic smooth_speed(input logic [COUNT_W-1:0] count, input logic [US_W-1:0] us_in,
                              output logic [SPEED_W-1:0] speed);
    logic [COUNT_W-1:0] delta;
    logic               neg;
    logic [63:0]        us;
    logic [63:0]        mag;
    logic [63:0]        num;
    logic [63:0]        smag;
    logic [63:0]        amag;
    logic [63:0]        fs;
    logic [63:0]        s;
    longint             raw;
    longint             diff;
    longint             base_a;
    longint             top_a;
    longint             alpha;
    longint             smooth;
    us    = (us_in == '0) ? 64'd1 : 64'(us_in);
    delta = count - last_count;
    neg   = delta[COUNT_W-1];
    mag   = {32'd0, (neg ? (32'd0 - delta) : delta)};
    num   = mag * 64'(sh_dpc);
    num   = (num << UP_SHIFT) >> DOWN_SHIFT;
    smag  = per_second(num, us);
    raw   = neg ? -longint'(smag) : longint'(smag);
    // acceleration sets the blend between base and max alpha
    diff  = raw - last_raw;
    amag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    amag  = per_second(amag, us);
    fs    = 64'(sh_afs) << FRAC_BITS;
    if (amag >= fs) s = 64'(UNITY);
    else s = (amag << 16) / fs;
    base_a = (sh_base > ONE_Q16) ? UNITY : longint'(sh_base);
    top_a  = (sh_max > ONE_Q16) ? UNITY : longint'(sh_max);
    alpha  = base_a + ((top_a - base_a) * longint'(s)) / UNITY;
    smooth = (alpha * raw + (UNITY - alpha) * last_smooth) / UNITY;
    last_count  = count;
    last_raw    = raw;
    last_smooth = smooth;
    speed = smooth[SPEED_W-1:0];
  endtask

  task automatic flag_fault(input string what, input logic [SPEED_W-1:0] exp_v,
                            input logic [SPEED_W-1:0] act_v);
    if (mismatch_count < 10)
      $display("mismatch: %s expected %h actual %h", what, exp_v, act_v);
    mismatch_count++;
  endtask

  // compare each returned speed with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_speed_q.size() == 0) flag_fault("unrequested result", '0, filtered_speed);
      else if (pending_speed_q[0] !== filtered_speed) begin
        flag_fault("filtered_speed", pending_speed_q[0], filtered_speed);
        void'(pending_speed_q.pop_front());
      end else void'(pending_speed_q.pop_front());
    end
  end

  // stall the result side in random bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 23)) @(negedge clk);
      end
    end
  end

  // offer one sample, hold it until taken, then predict its result
  task automatic send_sample(input logic [COUNT_W-1:0] count, input logic [US_W-1:0] us);
    logic [SPEED_W-1:0] speed;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pulse_count <= count;
    elapsed_us  <= us;
    do @(posedge clk); while (!in_ready);
    smooth_speed(count, us, speed);
    pending_speed_q.push_back(speed);
    shaft_count = count;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_speed_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DPC:  sh_dpc  = data[DPC_W-1:0];
      CFG_BASE: sh_base = data[ALPHA_W-1:0];
      CFG_MAX:  sh_max  = data[ALPHA_W-1:0];
      CFG_AFS:  sh_afs  = data[AFS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned lo, int unsigned hi,
                                                       int unsigned w);
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      2: return CFG_DATA_W'($urandom_range(0, (1 << w) - 1));
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // corner samples under the reset configuration
  task automatic test_reset_defaults();
    send_sample(32'd0, 20'd1000);
    send_sample(32'd100, 20'd1000);
    send_sample(32'd300, 20'd1000);
    send_sample(32'h7FFF_FFFF, 20'd1);
    send_sample(32'h8000_0000, 20'd1);
    send_sample(32'h7FFF_FFFF, 20'd0);
    send_sample(32'h0000_0000, 20'd1);
    send_sample(32'h8000_0000, 20'd1);
    send_sample(32'h8000_1000, 20'd1000000);
    send_sample(32'h8000_0000, 20'hFFFFF);
  endtask

  // register corners: zero gain, alphas above one, inverted alphas, full scale
  task automatic test_register_corners();
    settle_block();
    write_reg(CFG_DPC, 20'd0);
    send_sample(32'd5000, 20'd1000);
    settle_block();
    write_reg(CFG_DPC, 20'd65535);
    write_reg(CFG_BASE, 20'd0);
    write_reg(CFG_MAX, 20'd65536);
    send_sample(32'd9000, 20'd1000);
    send_sample(32'd9010, 20'd1000);
    settle_block();
    write_reg(CFG_BASE, 20'd131071);
    write_reg(CFG_MAX, 20'd0);
    send_sample(32'd12000, 20'd500);
    send_sample(32'hFFFF_0000, 20'd500);
    settle_block();
    write_reg(CFG_AFS, 20'd0);
    send_sample(32'hFFFF_0100, 20'd2000);
    send_sample(32'hFFFF_0101, 20'd2000);
    settle_block();
    write_reg(CFG_AFS, 20'd1000000);
    send_sample(32'hFFFF_8000, 20'd100);
    settle_block();
    write_reg(CFG_AFS, 20'hFFFFF);
    send_sample(32'h0000_8000, 20'd100);
    settle_block();
    // writes past the last register leave the block unchanged
    write_reg(CFG_AFS + 3'd1, 20'hFFFFF);
    write_reg(CFG_AFS + 3'd4, 20'h00001);
    send_sample(32'h0001_0000, 20'd1000);
  endtask

  // random shaft motion in segments, with noise samples mixed in
  task automatic run_motion(input int n_items);
    int          sent;
    int          seg_len;
    int          velocity;
    int          jerk;
    int unsigned nominal_us;
    logic [US_W-1:0] us;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample($urandom, US_W'($urandom));
        sent++;
      end else begin
        seg_len  = $urandom_range(4, 40);
        velocity = $urandom_range(0, 1 << $urandom_range(0, 18));
        if ($urandom_range(0, 1) == 1) velocity = -velocity;
        jerk     = $urandom_range(0, 1 << $urandom_range(0, 10));
        case ($urandom_range(0, 5))
          0:       nominal_us = $urandom_range(1, 1000000);
          1:       nominal_us = $urandom_range(1, 50);
          default: nominal_us = $urandom_range(200, 5000);
        endcase
        for (int k = 0; k < seg_len && sent < n_items; k++) begin
          velocity = velocity + $urandom_range(0, 2 * jerk) - jerk;
          us = US_W'(nominal_us + $urandom_range(0, nominal_us / 8));
          send_sample(shaft_count + velocity, us);
          sent++;
        end
      end
    end
  endtask

  // several random register settings, each followed by a stretch of motion
  task automatic test_random_motion();
    for (int phase = 0; phase < 7; phase++) begin
      settle_block();
      if (phase == 6) idle_on = 1'b0;
      write_reg(CFG_DPC, pick_value(1, 65535, DPC_W));
      write_reg(CFG_BASE, pick_value(0, 65536, ALPHA_W));
      write_reg(CFG_MAX, pick_value(0, 65536, ALPHA_W));
      write_reg(CFG_AFS, pick_value(1, 1000000, AFS_W));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_AFS + 3'(1 + $urandom_range(0, 3)), CFG_DATA_W'($urandom));
      run_motion(250);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    pulse_count = '0;
    elapsed_us  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_defaults();
    test_register_corners();
    test_random_motion();

    // drain and report
    settle_block();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_speed_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
